// File: sv/ictt_pkg.sv
// Shared types, opcode codes and timing tables for the instruction timing table.
`default_nettype none
package ictt_pkg;

  localparam int NumRows  = 44;
  localparam int ModeCols = 10;

  typedef logic [5:0] row_idx_t;

  typedef struct packed {
    logic [6:0] func;
    logic       word_size;
    logic [3:0] ea_mode;
    logic       short_form;
    logic       immediate_source;
    logic       immediate_is_8bit;
    logic [2:0] outcome;
    logic [3:0] register_count;
    logic       odd_start;
  } item_t;

  typedef struct packed {
    logic [5:0] base_states;
    logic [4:0] access_cycles;
    logic [2:0] fetch_bytes;
    logic [1:0] parity_extra;
  } result_t;

  // Opcodes in decoder order.
  localparam logic [6:0] OP_MOV    = 7'd0;
  localparam logic [6:0] OP_CMP    = 7'd1;
  localparam logic [6:0] OP_ADD    = 7'd2;
  localparam logic [6:0] OP_SUB    = 7'd3;
  localparam logic [6:0] OP_AND    = 7'd4;
  localparam logic [6:0] OP_OR     = 7'd5;
  localparam logic [6:0] OP_XOR    = 7'd6;
  localparam logic [6:0] OP_ADDX   = 7'd7;
  localparam logic [6:0] OP_SUBX   = 7'd8;
  localparam logic [6:0] OP_ADDS   = 7'd9;
  localparam logic [6:0] OP_SUBS   = 7'd10;
  localparam logic [6:0] OP_ADDQ   = 7'd11;
  localparam logic [6:0] OP_NEG    = 7'd12;
  localparam logic [6:0] OP_NOT    = 7'd13;
  localparam logic [6:0] OP_SHAL   = 7'd14;
  localparam logic [6:0] OP_SHAR   = 7'd15;
  localparam logic [6:0] OP_SHLL   = 7'd16;
  localparam logic [6:0] OP_SHLR   = 7'd17;
  localparam logic [6:0] OP_ROTL   = 7'd18;
  localparam logic [6:0] OP_ROTR   = 7'd19;
  localparam logic [6:0] OP_ROTXL  = 7'd20;
  localparam logic [6:0] OP_ROTXR  = 7'd21;
  localparam logic [6:0] OP_BSET   = 7'd22;
  localparam logic [6:0] OP_BCLR   = 7'd23;
  localparam logic [6:0] OP_BNOT   = 7'd24;
  localparam logic [6:0] OP_BTST   = 7'd25;
  localparam logic [6:0] OP_CLR    = 7'd26;
  localparam logic [6:0] OP_TST    = 7'd27;
  localparam logic [6:0] OP_TAS    = 7'd28;
  localparam logic [6:0] OP_MULXU  = 7'd29;
  localparam logic [6:0] OP_DIVXU  = 7'd30;
  localparam logic [6:0] OP_LDC    = 7'd31;
  localparam logic [6:0] OP_STC    = 7'd32;
  localparam logic [6:0] OP_ANDC   = 7'd33;
  localparam logic [6:0] OP_ORC    = 7'd34;
  localparam logic [6:0] OP_XORC   = 7'd35;
  localparam logic [6:0] OP_MOVFPE = 7'd36;
  localparam logic [6:0] OP_MOVTPE = 7'd37;
  localparam logic [6:0] OP_DADD   = 7'd38;
  localparam logic [6:0] OP_DSUB   = 7'd39;
  localparam logic [6:0] OP_EXTS   = 7'd40;
  localparam logic [6:0] OP_EXTU   = 7'd41;
  localparam logic [6:0] OP_SWAP   = 7'd42;
  localparam logic [6:0] OP_XCH    = 7'd43;
  localparam logic [6:0] OP_BCC    = 7'd44;
  localparam logic [6:0] OP_BSR    = 7'd45;
  localparam logic [6:0] OP_JMP    = 7'd46;
  localparam logic [6:0] OP_JSR    = 7'd47;
  localparam logic [6:0] OP_LDM    = 7'd48;
  localparam logic [6:0] OP_STM    = 7'd49;
  localparam logic [6:0] OP_LINK   = 7'd50;
  localparam logic [6:0] OP_NOP    = 7'd51;
  localparam logic [6:0] OP_RTD    = 7'd52;
  localparam logic [6:0] OP_RTE    = 7'd53;
  localparam logic [6:0] OP_RTS    = 7'd54;
  localparam logic [6:0] OP_SCB    = 7'd55;
  localparam logic [6:0] OP_SLEEP  = 7'd56;
  localparam logic [6:0] OP_TRAPA  = 7'd57;
  localparam logic [6:0] OP_TRAPVS = 7'd58;
  localparam logic [6:0] OP_UNLK   = 7'd59;
  localparam logic [6:0] OP_PJMP   = 7'd60;
  localparam logic [6:0] OP_PJSR   = 7'd61;
  localparam logic [6:0] OP_PRTS   = 7'd62;
  localparam logic [6:0] OP_PRTD   = 7'd63;
  localparam logic [6:0] OP_LAST   = 7'd63;

  // Addressing mode codes.
  localparam logic [3:0] EA_IND     = 4'd1;
  localparam logic [3:0] EA_D8      = 4'd2;
  localparam logic [3:0] EA_AA8     = 4'd6;
  localparam logic [3:0] EA_AA16    = 4'd7;
  localparam logic [3:0] EA_IMM     = 4'd8;
  localparam logic [3:0] EA_PCREL8  = 4'd9;
  localparam logic [3:0] EA_ABS24   = 4'd10;

  // Execution outcome codes.
  localparam logic [2:0] OUT_TAKEN    = 3'd1;
  localparam logic [2:0] OUT_DIV_OVF  = 3'd2;
  localparam logic [2:0] OUT_DIV_ZERO = 3'd3;
  localparam logic [2:0] OUT_LOOP_END = 3'd4;

  localparam logic [3:0] MAX_REGS = 4'd8;

  // Timing row indexes.
  localparam row_idx_t ROW_ALU_B   = 6'd0;
  localparam row_idx_t ROW_ALU_W   = 6'd1;
  localparam row_idx_t ROW_ADDS_B  = 6'd2;
  localparam row_idx_t ROW_ADDS_W  = 6'd3;
  localparam row_idx_t ROW_RMW_B   = 6'd4;
  localparam row_idx_t ROW_RMW_W   = 6'd5;
  localparam row_idx_t ROW_BITM_B  = 6'd6;
  localparam row_idx_t ROW_BITM_W  = 6'd7;
  localparam row_idx_t ROW_BTST_B  = 6'd8;
  localparam row_idx_t ROW_BTST_W  = 6'd9;
  localparam row_idx_t ROW_CLR_B   = 6'd10;
  localparam row_idx_t ROW_CLR_W   = 6'd11;
  localparam row_idx_t ROW_CMPG8   = 6'd12;
  localparam row_idx_t ROW_CMPG16  = 6'd13;
  localparam row_idx_t ROW_MOVG8   = 6'd14;
  localparam row_idx_t ROW_MOVG16  = 6'd15;
  localparam row_idx_t ROW_DIV_B   = 6'd16;
  localparam row_idx_t ROW_DIV_W   = 6'd17;
  localparam row_idx_t ROW_DZ_BMIN = 6'd18;
  localparam row_idx_t ROW_DZ_BMAX = 6'd19;
  localparam row_idx_t ROW_DZ_WMIN = 6'd20;
  localparam row_idx_t ROW_DZ_WMAX = 6'd21;
  localparam row_idx_t ROW_DOV_B   = 6'd22;
  localparam row_idx_t ROW_DOV_W   = 6'd23;
  localparam row_idx_t ROW_LDC_B   = 6'd24;
  localparam row_idx_t ROW_LDC_W   = 6'd25;
  localparam row_idx_t ROW_MOVPE   = 6'd26;
  localparam row_idx_t ROW_MUL_B   = 6'd27;
  localparam row_idx_t ROW_MUL_W   = 6'd28;
  localparam row_idx_t ROW_STC_B   = 6'd29;
  localparam row_idx_t ROW_STC_W   = 6'd30;
  localparam row_idx_t ROW_TAS     = 6'd31;
  localparam row_idx_t ROW_CTL     = 6'd32;
  localparam row_idx_t ROW_CMPE    = 6'd33;
  localparam row_idx_t ROW_CMPI    = 6'd34;
  localparam row_idx_t ROW_MOVE    = 6'd35;
  localparam row_idx_t ROW_MOVI    = 6'd36;
  localparam row_idx_t ROW_MOVLS_B = 6'd37;
  localparam row_idx_t ROW_MOVLS_W = 6'd38;
  localparam row_idx_t ROW_MOVF_B  = 6'd39;
  localparam row_idx_t ROW_MOVF_W  = 6'd40;
  localparam row_idx_t ROW_DADD    = 6'd41;
  localparam row_idx_t ROW_EXT     = 6'd42;
  localparam row_idx_t ROW_XCH     = 6'd43;

  // Access cycles (I) per row.
  localparam logic [3:0] ROW_I [NumRows] = '{
    4'd1, 4'd2, 4'd1, 4'd2, 4'd2, 4'd4, 4'd2, 4'd4, 4'd1, 4'd2,
    4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2, 4'd6, 4'd10,
    4'd6, 4'd10, 4'd1, 4'd2, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2, 4'd1,
    4'd2, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd2, 4'd1,
    4'd2, 4'd0, 4'd0, 4'd0
  };

  // Extra instruction bytes (K) per row.
  localparam logic [1:0] ROW_K [NumRows] = '{
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd1
  };

  // Base states per row and addressing mode column.
  localparam logic [5:0] ROW_C [NumRows][ModeCols] = '{
    '{6'd2, 6'd5, 6'd5, 6'd6, 6'd5, 6'd6, 6'd5, 6'd6, 6'd3, 6'd0},
    '{6'd2, 6'd5, 6'd5, 6'd6, 6'd5, 6'd6, 6'd5, 6'd6, 6'd0, 6'd4},
    '{6'd3, 6'd5, 6'd5, 6'd6, 6'd5, 6'd6, 6'd5, 6'd6, 6'd3, 6'd0},
    '{6'd3, 6'd5, 6'd5, 6'd6, 6'd5, 6'd6, 6'd5, 6'd6, 6'd0, 6'd4},
    '{6'd2, 6'd7, 6'd7, 6'd8, 6'd7, 6'd8, 6'd7, 6'd8, 6'd0, 6'd0},
    '{6'd2, 6'd7, 6'd7, 6'd8, 6'd7, 6'd8, 6'd7, 6'd8, 6'd0, 6'd0},
    '{6'd4, 6'd7, 6'd7, 6'd8, 6'd7, 6'd8, 6'd7, 6'd8, 6'd0, 6'd0},
    '{6'd4, 6'd7, 6'd7, 6'd8, 6'd7, 6'd8, 6'd7, 6'd8, 6'd0, 6'd0},
    '{6'd3, 6'd5, 6'd5, 6'd6, 6'd5, 6'd6, 6'd5, 6'd6, 6'd0, 6'd0},
    '{6'd3, 6'd5, 6'd5, 6'd6, 6'd5, 6'd6, 6'd5, 6'd6, 6'd0, 6'd0},
    '{6'd2, 6'd5, 6'd5, 6'd6, 6'd5, 6'd6, 6'd5, 6'd6, 6'd0, 6'd0},
    '{6'd2, 6'd5, 6'd5, 6'd6, 6'd5, 6'd6, 6'd5, 6'd6, 6'd0, 6'd0},
    '{6'd0, 6'd6, 6'd6, 6'd7, 6'd6, 6'd7, 6'd6, 6'd7, 6'd0, 6'd0},
    '{6'd0, 6'd7, 6'd7, 6'd8, 6'd7, 6'd8, 6'd7, 6'd8, 6'd0, 6'd0},
    '{6'd0, 6'd7, 6'd7, 6'd8, 6'd7, 6'd8, 6'd7, 6'd8, 6'd0, 6'd0},
    '{6'd0, 6'd8, 6'd8, 6'd9, 6'd8, 6'd9, 6'd8, 6'd9, 6'd0, 6'd0},
    '{6'd20, 6'd23, 6'd23, 6'd24, 6'd23, 6'd24, 6'd23, 6'd24, 6'd21, 6'd0},
    '{6'd26, 6'd29, 6'd29, 6'd30, 6'd29, 6'd30, 6'd29, 6'd30, 6'd0, 6'd28},
    '{6'd20, 6'd23, 6'd23, 6'd24, 6'd23, 6'd24, 6'd23, 6'd24, 6'd21, 6'd0},
    '{6'd25, 6'd28, 6'd28, 6'd29, 6'd28, 6'd29, 6'd28, 6'd29, 6'd26, 6'd0},
    '{6'd20, 6'd23, 6'd23, 6'd24, 6'd23, 6'd24, 6'd23, 6'd24, 6'd0, 6'd27},
    '{6'd25, 6'd28, 6'd28, 6'd29, 6'd28, 6'd29, 6'd28, 6'd29, 6'd0, 6'd32},
    '{6'd8, 6'd11, 6'd11, 6'd12, 6'd11, 6'd12, 6'd11, 6'd12, 6'd9, 6'd0},
    '{6'd8, 6'd11, 6'd11, 6'd12, 6'd11, 6'd12, 6'd11, 6'd12, 6'd0, 6'd10},
    '{6'd3, 6'd6, 6'd6, 6'd7, 6'd6, 6'd7, 6'd6, 6'd7, 6'd4, 6'd0},
    '{6'd4, 6'd7, 6'd7, 6'd8, 6'd7, 6'd8, 6'd7, 6'd8, 6'd0, 6'd6},
    '{6'd0, 6'd13, 6'd13, 6'd14, 6'd13, 6'd13, 6'd13, 6'd14, 6'd0, 6'd0},
    '{6'd16, 6'd19, 6'd19, 6'd20, 6'd19, 6'd20, 6'd19, 6'd20, 6'd18, 6'd0},
    '{6'd23, 6'd25, 6'd25, 6'd26, 6'd25, 6'd26, 6'd25, 6'd26, 6'd0, 6'd25},
    '{6'd4, 6'd7, 6'd7, 6'd8, 6'd7, 6'd8, 6'd7, 6'd8, 6'd0, 6'd0},
    '{6'd4, 6'd7, 6'd7, 6'd8, 6'd7, 6'd8, 6'd7, 6'd8, 6'd0, 6'd0},
    '{6'd4, 6'd7, 6'd7, 6'd8, 6'd7, 6'd8, 6'd7, 6'd8, 6'd0, 6'd0},
    '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd5, 6'd9},
    '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd2, 6'd0},
    '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd3},
    '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd2, 6'd0},
    '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd3},
    '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd5, 6'd0, 6'd0, 6'd0},
    '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd5, 6'd0, 6'd0, 6'd0},
    '{6'd0, 6'd0, 6'd5, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd0, 6'd0, 6'd5, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd4, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd3, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd4, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}
  };

  // Instruction bytes (J) per addressing mode column.
  localparam logic [1:0] MODE_BYTES [ModeCols] = '{
    2'd1, 2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
  };

  // Parity extras for MOV with a 16-bit immediate source, modes 0..7.
  localparam logic [1:0] MOVW_EVEN [8] = '{2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd0, 2'd2};
  localparam logic [1:0] MOVW_ODD  [8] = '{2'd0, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0};

  // Parity extras for the general format per column.
  localparam logic GEN_EVEN [ModeCols] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                           1'b0, 1'b0};
  localparam logic GEN_ODD  [ModeCols] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                                           1'b0, 1'b0};

endpackage
`default_nettype wire

// File: sv/ictt_lookup.sv
// Timing decode: maps one registered instruction to its timing record.
`default_nettype none
module ictt_lookup
  import ictt_pkg::*;
(
  input  item_t   item,
  input  logic    max_mode,
  output result_t result
);

  logic       col_valid;
  logic [3:0] col;
  logic [3:0] col_idx;
  logic [3:0] nr;
  logic       taken;
  logic       use_row;
  row_idx_t   row;
  logic [5:0] fix_s;
  logic [4:0] fix_i;
  logic [2:0] fix_jk;
  logic [1:0] dz_extra;
  logic [1:0] par;

  always_comb begin
    if (item.ea_mode <= EA_AA16) begin
      col       = item.ea_mode;
      col_valid = 1'b1;
    end else if (item.ea_mode == EA_IMM) begin
      col       = item.word_size ? 4'd9 : 4'd8;
      col_valid = 1'b1;
    end else begin
      col       = 4'd0;
      col_valid = 1'b0;
    end
  end

  assign col_idx = col_valid ? col : 4'd0;
  assign nr      = (item.register_count > MAX_REGS) ? MAX_REGS : item.register_count;
  assign taken   = (item.outcome == OUT_TAKEN);

  always_comb begin
    use_row  = 1'b1;
    row      = ROW_ALU_B;
    fix_s    = 6'd0;
    fix_i    = 5'd0;
    fix_jk   = 3'd0;
    dz_extra = 2'd0;
    case (item.func)
      OP_MOV: begin
        if (item.short_form) begin
          if (item.ea_mode == EA_IMM) begin
            row = item.word_size ? ROW_MOVI : ROW_MOVE;
          end else if (item.ea_mode == EA_AA8) begin
            row = item.word_size ? ROW_MOVLS_W : ROW_MOVLS_B;
          end else begin
            row = item.word_size ? ROW_MOVF_W : ROW_MOVF_B;
          end
        end else if (item.immediate_source) begin
          row = item.immediate_is_8bit ? ROW_MOVG8 : ROW_MOVG16;
        end else begin
          row = item.word_size ? ROW_ALU_W : ROW_ALU_B;
        end
      end
      OP_CMP: begin
        if (item.short_form) begin
          row = item.word_size ? ROW_CMPI : ROW_CMPE;
        end else if (item.immediate_source) begin
          row = item.immediate_is_8bit ? ROW_CMPG8 : ROW_CMPG16;
        end else begin
          row = item.word_size ? ROW_ALU_W : ROW_ALU_B;
        end
      end
      OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_ADDX, OP_SUBX: begin
        row = item.word_size ? ROW_ALU_W : ROW_ALU_B;
      end
      OP_ADDS, OP_SUBS: begin
        row = item.word_size ? ROW_ADDS_W : ROW_ADDS_B;
      end
      OP_ADDQ, OP_NEG, OP_NOT, OP_SHAL, OP_SHAR, OP_SHLL, OP_SHLR, OP_ROTL, OP_ROTR,
      OP_ROTXL, OP_ROTXR: begin
        row = item.word_size ? ROW_RMW_W : ROW_RMW_B;
      end
      OP_BSET, OP_BCLR, OP_BNOT: begin
        row = item.word_size ? ROW_BITM_W : ROW_BITM_B;
      end
      OP_BTST: begin
        row = item.word_size ? ROW_BTST_W : ROW_BTST_B;
      end
      OP_CLR, OP_TST: begin
        row = item.word_size ? ROW_CLR_W : ROW_CLR_B;
      end
      OP_TAS:   row = ROW_TAS;
      OP_MULXU: row = item.word_size ? ROW_MUL_W : ROW_MUL_B;
      OP_DIVXU: begin
        if (item.outcome == OUT_DIV_OVF) begin
          row = item.word_size ? ROW_DOV_W : ROW_DOV_B;
        end else if (item.outcome == OUT_DIV_ZERO) begin
          if (item.word_size) begin
            row = max_mode ? ROW_DZ_WMAX : ROW_DZ_WMIN;
          end else begin
            row = max_mode ? ROW_DZ_BMAX : ROW_DZ_BMIN;
          end
          // A memory operand costs extra bus cycles on the zero-divide trap.
          if (item.ea_mode >= EA_IND && item.ea_mode <= EA_AA16) begin
            dz_extra = item.word_size ? 2'd2 : 2'd1;
          end
        end else begin
          row = item.word_size ? ROW_DIV_W : ROW_DIV_B;
        end
      end
      OP_LDC:                   row = item.word_size ? ROW_LDC_W : ROW_LDC_B;
      OP_STC:                   row = item.word_size ? ROW_STC_W : ROW_STC_B;
      OP_ANDC, OP_ORC, OP_XORC: row = ROW_CTL;
      OP_MOVFPE, OP_MOVTPE:     row = ROW_MOVPE;
      OP_DADD, OP_DSUB:         row = ROW_DADD;
      OP_EXTS, OP_EXTU, OP_SWAP: row = ROW_EXT;
      OP_XCH:                   row = ROW_XCH;
      OP_BCC: begin
        use_row = 1'b0;
        fix_s   = taken ? 6'd7 : 6'd3;
        if (item.ea_mode == EA_PCREL8) begin
          fix_jk = taken ? 3'd5 : 3'd2;
        end else begin
          fix_jk = taken ? 3'd6 : 3'd3;
        end
      end
      OP_BSR: begin
        use_row = 1'b0;
        fix_s   = 6'd9;
        fix_i   = 5'd2;
        fix_jk  = (item.ea_mode == EA_PCREL8) ? 3'd4 : 3'd5;
      end
      OP_JMP: begin
        use_row = 1'b0;
        if (item.ea_mode == EA_AA16 || item.ea_mode == EA_D8) begin
          fix_s  = 6'd7;
          fix_jk = 3'd5;
        end else if (item.ea_mode == EA_IND) begin
          fix_s  = 6'd6;
          fix_jk = 3'd5;
        end else begin
          fix_s  = 6'd8;
          fix_jk = 3'd6;
        end
      end
      OP_JSR: begin
        use_row = 1'b0;
        fix_i   = 5'd2;
        if (item.ea_mode == EA_AA16 || item.ea_mode == EA_IND || item.ea_mode == EA_D8) begin
          fix_s  = 6'd9;
          fix_jk = 3'd5;
        end else begin
          fix_s  = 6'd10;
          fix_jk = 3'd6;
        end
      end
      OP_LDM: begin
        use_row = 1'b0;
        fix_s   = 6'd6 + {nr, 2'b00};
        fix_i   = {nr, 1'b0};
        fix_jk  = 3'd2;
      end
      OP_STM: begin
        use_row = 1'b0;
        fix_s   = 6'd6 + {2'b00, nr} + {1'b0, nr, 1'b0};
        fix_i   = {nr, 1'b0};
        fix_jk  = 3'd2;
      end
      OP_LINK: begin
        use_row = 1'b0;
        fix_s   = item.immediate_is_8bit ? 6'd6 : 6'd7;
        fix_i   = 5'd2;
        fix_jk  = item.immediate_is_8bit ? 3'd2 : 3'd3;
      end
      OP_NOP: begin
        use_row = 1'b0;
        fix_s   = 6'd2;
        fix_jk  = 3'd1;
      end
      OP_RTD: begin
        use_row = 1'b0;
        fix_s   = 6'd9;
        fix_i   = 5'd2;
        fix_jk  = item.immediate_is_8bit ? 3'd4 : 3'd5;
      end
      OP_RTE: begin
        use_row = 1'b0;
        fix_s   = max_mode ? 6'd15 : 6'd13;
        fix_i   = max_mode ? 5'd6 : 5'd4;
        fix_jk  = 3'd4;
      end
      OP_RTS: begin
        use_row = 1'b0;
        fix_s   = 6'd8;
        fix_i   = 5'd2;
        fix_jk  = 3'd4;
      end
      OP_SCB: begin
        use_row = 1'b0;
        if (taken) begin
          fix_s  = 6'd8;
          fix_jk = 3'd6;
        end else begin
          fix_s  = (item.outcome == OUT_LOOP_END) ? 6'd4 : 6'd3;
          fix_jk = 3'd3;
        end
      end
      OP_SLEEP: begin
        use_row = 1'b0;
        fix_s   = 6'd2;
      end
      OP_TRAPA: begin
        use_row = 1'b0;
        fix_s   = max_mode ? 6'd22 : 6'd17;
        fix_i   = max_mode ? 5'd10 : 5'd6;
        fix_jk  = 3'd4;
      end
      OP_TRAPVS: begin
        use_row = 1'b0;
        if (!taken) begin
          fix_s  = 6'd3;
          fix_jk = 3'd1;
        end else begin
          fix_s  = max_mode ? 6'd23 : 6'd18;
          fix_i  = max_mode ? 5'd10 : 5'd6;
          fix_jk = 3'd4;
        end
      end
      OP_UNLK: begin
        use_row = 1'b0;
        fix_s   = 6'd5;
        fix_i   = 5'd2;
        fix_jk  = 3'd1;
      end
      OP_PJMP: begin
        use_row = 1'b0;
        fix_s   = (item.ea_mode == EA_ABS24) ? 6'd9 : 6'd8;
        fix_jk  = (item.ea_mode == EA_ABS24) ? 3'd6 : 3'd5;
      end
      OP_PJSR: begin
        use_row = 1'b0;
        fix_s   = (item.ea_mode == EA_ABS24) ? 6'd15 : 6'd13;
        fix_i   = 5'd4;
        fix_jk  = (item.ea_mode == EA_ABS24) ? 3'd6 : 3'd5;
      end
      OP_PRTS: begin
        use_row = 1'b0;
        fix_s   = 6'd12;
        fix_i   = 5'd4;
        fix_jk  = 3'd5;
      end
      OP_PRTD: begin
        use_row = 1'b0;
        fix_s   = 6'd13;
        fix_i   = 5'd4;
        fix_jk  = item.immediate_is_8bit ? 3'd5 : 3'd6;
      end
      default: begin
        // Invalid opcode: all fields stay zero.
        use_row = 1'b0;
      end
    endcase
  end

  always_comb begin
    par = 2'd0;
    case (item.func)
      OP_BSR, OP_JMP, OP_JSR, OP_RTD, OP_RTE, OP_RTS, OP_TRAPA, OP_PJMP, OP_PJSR,
      OP_PRTS, OP_PRTD: begin
        par = {1'b0, item.odd_start};
      end
      OP_BCC, OP_SCB, OP_TRAPVS: begin
        par = {1'b0, taken & item.odd_start};
      end
      OP_MOVFPE, OP_MOVTPE: begin
        par = 2'd1;
      end
      default: begin
        if (item.func > OP_LAST) begin
          par = 2'd0;
        end else if (item.func == OP_MOV && item.immediate_source && !item.short_form) begin
          if (item.immediate_is_8bit) begin
            par = 2'd1;
          end else if (item.ea_mode <= EA_AA16) begin
            par = item.odd_start ? MOVW_ODD[item.ea_mode[2:0]] : MOVW_EVEN[item.ea_mode[2:0]];
          end
        end else if (col_valid) begin
          par = {1'b0, item.odd_start ? GEN_ODD[col_idx] : GEN_EVEN[col_idx]};
        end
      end
    endcase
  end

  always_comb begin
    if (use_row) begin
      result.base_states   = col_valid ? ROW_C[row][col_idx] : 6'd0;
      result.access_cycles = {1'b0, ROW_I[row]} + {3'b000, dz_extra};
      result.fetch_bytes   = {1'b0, ROW_K[row]} +
                             (col_valid ? {1'b0, MODE_BYTES[col_idx]} : 3'd0);
    end else begin
      result.base_states   = fix_s;
      result.access_cycles = fix_i;
      result.fetch_bytes   = fix_jk;
    end
    result.parity_extra = par;
  end

endmodule
`default_nettype wire

// File: sv/instruction_cycle_timing_table.sv
// Top level of the instruction timing table: input register, decode and result register.
//
// Usage: one decoded instruction enters per transaction on the in_ channel
// (valid/ready); one timing record leaves per transaction on the out_ channel.
// Each instruction gives exactly one record, in order.
// An accepted instruction passes through the input register, then the result
// register, before its record is offered on out_valid.
// Throughput: one instruction per cycle while out_ready stays high; the table
// decode between the two registers is combinational.
// When the receiver holds out_ready low, the result register holds its record
// and the input register still takes one more instruction; in_ready falls
// only once both registers are full.
// The cfg_ channel writes the maximum-mode bit; cfg_ready is always high. The user
// must write the bit only while no instruction is in flight; the block does not enforce it.
// Reset (rst_n low, synchronous) empties both registers and clears the
// maximum-mode bit to minimum mode.
`default_nettype none
module instruction_cycle_timing_table
  import ictt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [6:0] in_func,
  input  wire logic       in_word_size,
  input  wire logic [3:0] in_ea_mode,
  input  wire logic       in_short_form,
  input  wire logic       in_immediate_source,
  input  wire logic       in_immediate_is_8bit,
  input  wire logic [2:0] in_outcome,
  input  wire logic [3:0] in_register_count,
  input  wire logic       in_odd_start,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [5:0]      out_base_states,
  output logic [4:0]      out_access_cycles,
  output logic [2:0]      out_fetch_bytes,
  output logic [1:0]      out_parity_extra,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_maximum_mode
);

  logic    max_mode_r;
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res_nxt;
  logic    advance;
  item_t   in_item;

  assign in_item = '{func: in_func, word_size: in_word_size, ea_mode: in_ea_mode,
                     short_form: in_short_form, immediate_source: in_immediate_source,
                     immediate_is_8bit: in_immediate_is_8bit, outcome: in_outcome,
                     register_count: in_register_count, odd_start: in_odd_start};

  // The result register can load whenever it is empty or being drained.
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      max_mode_r <= cfg_maximum_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  ictt_lookup u_lookup (
    .item     (s1_item_r),
    .max_mode (max_mode_r),
    .result   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_base_states   = out_res_r.base_states;
  assign out_access_cycles = out_res_r.access_cycles;
  assign out_fetch_bytes   = out_res_r.fetch_bytes;
  assign out_parity_extra  = out_res_r.parity_extra;

`ifndef SYNTH
  // An instruction waiting behind a stalled record must not be dropped.
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> s1_valid_r)
    else $error("pending instruction lost during output stall");

  // A registered instruction moves into the result register when it can.
  a_move_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("instruction did not reach the result register");

  // Invalid opcodes produce an all-zero record.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && (s1_item_r.func > OP_LAST)) |=>
    (out_base_states == 6'd0 && out_access_cycles == 5'd0 &&
     out_fetch_bytes == 3'd0 && out_parity_extra == 2'd0))
    else $error("invalid opcode gave a nonzero record");

  // The parity adjustment never exceeds two states.
  a_parity_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_parity_extra != 2'd3))
    else $error("parity adjustment out of range");

  // Reset leaves both pipeline registers empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire
